// ----- design/tfpe_pkg.sv -----
// shared types and constants for the target frame pose error block
// no dependencies
package tfpe_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned CordW  = 56;   // cordic datapath width
  localparam int unsigned PosW   = 32;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned StandW = 16;
  localparam int unsigned VecGuard = 20;
  localparam int unsigned PosGuard = 16;
  localparam logic [33:0] MmGainC = 34'd10188013657;
  localparam logic [15:0] StandoffReset = 16'd1000;

  typedef struct packed {
    logic signed [CordW-1:0] vx;
    logic signed [CordW-1:0] vy;
    logic signed [CordW-1:0] px;
    logic signed [CordW-1:0] py;
    logic signed [DiffW-1:0] dz;
  } rot_t;

endpackage

// ----- design/tfpe_prep.sv -----
// front end: offsets, yaw vector from the quaternion, half-turn pre-rotation
// depends on tfpe_pkg
module tfpe_prep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  vehicle_x_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  vehicle_y_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  vehicle_z_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  target_x_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  target_y_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  target_z_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_x_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_y_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_z_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_w_i,
  output logic                              valid_o,
  output tfpe_pkg::rot_t                    data_o
);
  import tfpe_pkg::*;

  logic                    v1_q;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic signed [31:0]      qyy_q, qzz_q, qxy_q, qwz_q;
  logic signed [33:0]      vx, vy;
  logic signed [CordW-1:0] vxs, vys, pxs, pys;
  rot_t                    data_d, data_q;
  logic                    v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= DiffW'(vehicle_x_i) - DiffW'(target_x_i);
    dy_q  <= DiffW'(vehicle_y_i) - DiffW'(target_y_i);
    dz_q  <= DiffW'(vehicle_z_i) - DiffW'(target_z_i);
    qyy_q <= quat_y_i * quat_y_i;
    qzz_q <= quat_z_i * quat_z_i;
    qxy_q <= quat_x_i * quat_y_i;
    qwz_q <= quat_w_i * quat_z_i;
    data_q <= data_d;
  end

  always_comb begin
    vx = (34'sd1 <<< 28) - ((34'(qyy_q) + 34'(qzz_q)) <<< 1);
    vy = (34'(qxy_q) + 34'(qwz_q)) <<< 1;
    // degenerate yaw vector points along +x
    if (vx == '0 && vy == '0) vx = 34'sd1;
    vxs = CordW'(vx) <<< VecGuard;
    vys = CordW'(vy) <<< VecGuard;
    pxs = CordW'(dx_q) <<< PosGuard;
    pys = CordW'(dy_q) <<< PosGuard;
    if (vx < 0) begin
      data_d.vx = -vxs;
      data_d.vy = -vys;
      data_d.px = -pxs;
      data_d.py = -pys;
    end else begin
      data_d.vx = vxs;
      data_d.vy = vys;
      data_d.px = pxs;
      data_d.py = pys;
    end
    data_d.dz = dz_q;
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

// ----- design/tfpe_cell.sv -----
// one cordic micro-rotation cell, vectoring on the yaw vector
// depends on tfpe_pkg
module tfpe_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  tfpe_pkg::rot_t data_i,
  output logic           valid_o,
  output tfpe_pkg::rot_t data_o
);
  import tfpe_pkg::*;

  logic valid_q;
  rot_t data_d, data_q;

  always_comb begin
    data_d.dz = data_i.dz;
    if (data_i.vy >= 0) begin
      data_d.vx = data_i.vx + (data_i.vy >>> Shift);
      data_d.vy = data_i.vy - (data_i.vx >>> Shift);
      data_d.px = data_i.px + (data_i.py >>> Shift);
      data_d.py = data_i.py - (data_i.px >>> Shift);
    end else begin
      data_d.vx = data_i.vx - (data_i.vy >>> Shift);
      data_d.vy = data_i.vy + (data_i.vx >>> Shift);
      data_d.px = data_i.px - (data_i.py >>> Shift);
      data_d.py = data_i.py + (data_i.px >>> Shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/tfpe_scale.sv -----
// back end: gain removal, mm scaling, standoff, saturation
// depends on tfpe_pkg
module tfpe_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  tfpe_pkg::rot_t                     data_i,
  input  logic [tfpe_pkg::StandW-1:0]        standoff_i,
  output logic                               valid_o,
  output logic signed [31:0]                 along_error_mm_o,
  output logic [30:0]                        across_error_mm_o,
  output logic signed [31:0]                 height_error_mm_o
);
  import tfpe_pkg::*;

  localparam int unsigned MagW = CordW - PosGuard;

  logic                    v1_q, v2_q, v3_q;
  logic signed [MagW-1:0]  rx, ry;
  logic [MagW-1:0]         mx_q, my_q;
  logic                    ny_q, ny2_q, nz_q, nz2_q;
  logic [DiffW-1:0]        mz_q;
  logic [53:0]             axc_q, bxc_q, ayc_q, byc_q;
  logic [42:0]             hz_q;
  logic [35:0]             r_x, r_y;
  logic signed [37:0]      al;
  logic [26:0]             hm;
  logic signed [31:0]      along_q;
  logic [30:0]             across_q;
  logic signed [31:0]      height_q;

  always_comb begin
    rx = MagW'((data_i.px + (CordW'(1) <<< (PosGuard - 1))) >>> PosGuard);
    ry = MagW'((data_i.py + (CordW'(1) <<< (PosGuard - 1))) >>> PosGuard);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // magnitudes and signs, the across part keeps only its magnitude
  always_ff @(posedge clk_i) begin
    ny_q <= ry[MagW-1];
    mx_q <= rx[MagW-1] ? MagW'(-rx) : MagW'(rx);
    my_q <= ry[MagW-1] ? MagW'(-ry) : MagW'(ry);
    nz_q <= data_i.dz[DiffW-1];
    mz_q <= data_i.dz[DiffW-1] ? DiffW'(-data_i.dz) : DiffW'(data_i.dz);
  end

  // gain products on 20-bit halves
  always_ff @(posedge clk_i) begin
    axc_q <= 54'(mx_q[MagW-1:20]) * 54'(MmGainC);
    bxc_q <= 54'(mx_q[19:0]) * 54'(MmGainC);
    ayc_q <= 54'(my_q[MagW-1:20]) * 54'(MmGainC);
    byc_q <= 54'(my_q[19:0]) * 54'(MmGainC);
    hz_q  <= 43'(mz_q) * 43'd1000;
    ny2_q <= ny_q;
    nz2_q <= nz_q;
  end

  always_comb begin
    r_x = 36'((55'(axc_q) + 55'(1 << 19) + 55'(bxc_q >> 20)) >> 20);
    r_y = 36'((55'(ayc_q) + 55'(1 << 19) + 55'(byc_q >> 20)) >> 20);
    al  = (ny2_q ? -38'(r_y) : 38'(r_y)) - 38'(standoff_i);
    hm  = 27'((hz_q + 43'd32768) >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (al > 38'sh7FFFFFFF) along_q <= 32'sh7FFFFFFF;
    else if (al < -38'sh80000000) along_q <= 32'sh80000000;
    else along_q <= al[31:0];
    across_q <= (r_x > 36'h7FFFFFFF) ? 31'h7FFFFFFF : r_x[30:0];
    height_q <= nz2_q ? -32'(hm) : 32'(hm);
  end

  assign valid_o           = v3_q;
  assign along_error_mm_o  = along_q;
  assign across_error_mm_o = across_q;
  assign height_error_mm_o = height_q;

endmodule

// ----- design/target_frame_pose_error.sv -----
// top level of the target frame pose error block
// depends on tfpe_pkg, tfpe_prep, tfpe_cell, tfpe_scale
//
// usage:
//  - an item is taken at a clock edge with start high and busy low; busy
//    stays low, so an item may be started in every cycle
//  - each item gives one result, shown for exactly one cycle with done_o
//    high; the receiver cannot stall, results are never held
//  - from the accepting edge, an item passes through two front stages
//    (offsets, quaternion products, yaw vector), one cordic cell per
//    stage and three back stages (rounding, gain products, scaling and
//    saturation) before the edge that takes the result
//  - throughput is one item per cycle; no stage of the pipeline stalls
//  - the standoff register is written through cfg_valid_i/cfg_ready_o,
//    always ready; write it only while no item is in flight
//  - reset empties the pipeline (no results come out) and sets the
//    standoff to 1000 mm
module target_frame_pose_error #(
  parameter int unsigned CORDIC_STAGES = tfpe_pkg::CordicStagesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tfpe_pkg::PosW-1:0]  vehicle_x_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  vehicle_y_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  vehicle_z_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  target_x_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  target_y_i,
  input  logic signed [tfpe_pkg::PosW-1:0]  target_z_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_x_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_y_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_z_i,
  input  logic signed [tfpe_pkg::QuatW-1:0] quat_w_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tfpe_pkg::StandW-1:0]       cfg_data_i,
  output logic                              done_o,
  output logic signed [31:0]                along_error_mm_o,
  output logic [30:0]                       across_error_mm_o,
  output logic signed [31:0]                height_error_mm_o
);
  import tfpe_pkg::*;

  localparam int unsigned Latency = CORDIC_STAGES + 5;

  logic [StandW-1:0] standoff_q;
  logic              valid_c [CORDIC_STAGES+1];
  rot_t              data_c  [CORDIC_STAGES+1];

  // never stalls: a new item may enter every cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      standoff_q <= StandoffReset;
    end else if (cfg_valid_i) begin
      standoff_q <= cfg_data_i;
    end
  end

  tfpe_prep u_prep (
    .clk_i, .rst_ni,
    .valid_i     (start & ~busy),
    .vehicle_x_i, .vehicle_y_i, .vehicle_z_i,
    .target_x_i,  .target_y_i,  .target_z_i,
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .valid_o     (valid_c[0]),
    .data_o      (data_c[0])
  );

  // chain of cordic cells, cell i shifts by i
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    tfpe_cell #(.Shift(i)) u_cell (
      .clk_i, .rst_ni,
      .valid_i (valid_c[i]),
      .data_i  (data_c[i]),
      .valid_o (valid_c[i+1]),
      .data_o  (data_c[i+1])
    );
  end

  tfpe_scale u_scale (
    .clk_i, .rst_ni,
    .valid_i           (valid_c[CORDIC_STAGES]),
    .data_i            (data_c[CORDIC_STAGES]),
    .standoff_i        (standoff_q),
    .valid_o           (done_o),
    .along_error_mm_o,
    .across_error_mm_o,
    .height_error_mm_o
  );

`ifndef SYNTH
  // every started item comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##Latency done_o) else $error("result missing after latency");
  // no result without a started item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Latency)) else $error("result without item");
  // a valid at the first cell goes back to a start handed to the front end, through its registers v1_q and v2_q
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c[0] |-> $past(start, 2)) else $error("front end valid mismatch");
`endif

endmodule
